### rtl/mmiq_pkg.sv
// Shared types, codes and constants of the multi-mode input qualifier.
`timescale 1ns / 1ps
`default_nettype none
package mmiq_pkg;

  // Field widths
  localparam int SAMPLE_BITS = 10;
  localparam int CNT_BITS    = 16;
  localparam int THR_BITS    = 10;
  localparam int MODE_BITS   = 3;
  localparam int CMD_BITS    = 2;
  localparam int SUM_BITS    = SAMPLE_BITS + CNT_BITS;
  localparam int DCNT_BITS   = $clog2(SUM_BITS);
  localparam int CFG_IDX_BITS  = 2;
  localparam int CFG_DATA_BITS = 16;

  localparam logic [SAMPLE_BITS-1:0] SAMPLE_MAX = {SAMPLE_BITS{1'b1}};

  // Register reset values
  localparam logic [MODE_BITS-1:0] MODE_RESET     = 3'd0;
  localparam logic [THR_BITS-1:0]  THRESH_RESET   = 10'd700;
  localparam logic [CNT_BITS-1:0]  LEN_RESET      = 16'd1000;
  localparam logic [CNT_BITS-1:0]  DEBOUNCE_RESET = 16'd50;

  // Mode codes
  localparam logic [MODE_BITS-1:0] MODE_DIGITAL = 3'd0;
  localparam logic [MODE_BITS-1:0] MODE_PUSH    = 3'd1;
  localparam logic [MODE_BITS-1:0] MODE_SWITCH  = 3'd2;
  localparam logic [MODE_BITS-1:0] MODE_ANALOG  = 3'd3;
  localparam logic [MODE_BITS-1:0] MODE_INV_AN  = 3'd4;
  localparam logic [MODE_BITS-1:0] MODE_INTEG   = 3'd5;

  // Command codes
  localparam logic [CMD_BITS-1:0] CMD_TICK   = 2'd0;
  localparam logic [CMD_BITS-1:0] CMD_QUERY  = 2'd1;
  localparam logic [CMD_BITS-1:0] CMD_LOAD   = 2'd2;
  localparam logic [CMD_BITS-1:0] CMD_PARITY = 2'd3;

  // Register indexes
  localparam logic [CFG_IDX_BITS-1:0] REG_MODE     = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_THRESH   = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_LEN      = 2'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_DEBOUNCE = 2'd3;

  typedef struct packed {
    logic [CMD_BITS-1:0]    cmd;
    logic                   pin_level;
    logic [SAMPLE_BITS-1:0] analog_sample;
    logic [CNT_BITS-1:0]    load_value;
  } in_word_t;

  typedef struct packed {
    logic                   state_bit;
    logic [SAMPLE_BITS-1:0] level_value;
    logic [CNT_BITS-1:0]    press_total;
  } out_word_t;

  // Controller to datapath
  typedef struct packed {
    logic take;
    logic div_step;
    logic emit;
  } ctl_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic need_div;
    logic div_last;
  } dp_stat_t;

endpackage
`default_nettype wire

### rtl/mmiq_ctrl.sv
// Controller state machine: accept, divide sequencing and result hand-off.
`timescale 1ns / 1ps
`default_nettype none
module mmiq_ctrl
  import mmiq_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  output logic          in_ready_o,
  output logic          out_valid_o,
  input  wire logic     out_ready_i,
  input  wire dp_stat_t stat_i,
  output ctl_cmd_t      cmd_o
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_DIV  = 2'd1;
  localparam logic [1:0] ST_EMIT = 2'd2;

  logic [1:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;

  // Commands
  always_comb begin
    cmd_o.take     = (state_q == ST_IDLE) && in_valid_i;
    cmd_o.div_step = (state_q == ST_DIV);
    cmd_o.emit     = (state_q == ST_EMIT) && (!out_valid_q || out_ready_i);
  end

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) state_d = stat_i.need_div ? ST_DIV : ST_EMIT;
      end
      ST_DIV: begin
        if (stat_i.div_last) state_d = ST_EMIT;
      end
      ST_EMIT: begin
        if (cmd_o.emit) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Output word valid
  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.emit) out_valid_d = 1'b1;
    else if (out_ready_i) out_valid_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule
`default_nettype wire

### rtl/mmiq_dpath.sv
// Datapath: config registers, qualifier state, serial divider, result registers.
`timescale 1ns / 1ps
`default_nettype none
module mmiq_dpath
  import mmiq_pkg::*;
#(
  parameter int TIME_BITS = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire in_word_t                 in_word_i,
  input  wire ctl_cmd_t                 cmd_i,
  output dp_stat_t                      stat_o,
  input  wire logic                     cfg_we_i,
  input  wire logic [CFG_IDX_BITS-1:0]  cfg_idx_i,
  input  wire logic [CFG_DATA_BITS-1:0] cfg_wdata_i,
  output out_word_t                     out_word_o
);

  localparam int TW = (TIME_BITS > CNT_BITS) ? TIME_BITS : CNT_BITS;
  localparam logic [TIME_BITS-1:0] TICK_MAX = {TIME_BITS{1'b1}};
  localparam logic [DCNT_BITS-1:0] DCNT_LAST = DCNT_BITS'(SUM_BITS - 1);

  // Config registers
  logic [MODE_BITS-1:0] mode_q;
  logic [THR_BITS-1:0]  thresh_q;
  logic [CNT_BITS-1:0]  len_q;
  logic [CNT_BITS-1:0]  deb_q;

  // Qualifier state
  logic                   last_q, last_d;
  logic [TIME_BITS-1:0]   ticks_q, ticks_d;
  logic [CNT_BITS-1:0]    press_q, press_d;
  logic [SUM_BITS-1:0]    sum_q, sum_d;
  logic [CNT_BITS-1:0]    idx_q, idx_d;
  logic [SAMPLE_BITS-1:0] avg_q, avg_d;

  // Divider and result
  logic [CNT_BITS-1:0]  rem_q, rem_d;
  logic [SUM_BITS-1:0]  quot_q, quot_d;
  logic [DCNT_BITS-1:0] dcnt_q, dcnt_d;
  out_word_t            res_q, res_d;
  out_word_t            out_q;

  logic [CNT_BITS-1:0]    len_eff;
  logic [CNT_BITS-1:0]    idx_inc;
  logic [SUM_BITS-1:0]    sum_add;
  logic                   blk_done;
  logic                   push_chg;
  logic [SAMPLE_BITS-1:0] inv_val;
  logic [CNT_BITS:0]      rem_sh;
  logic                   rem_ge;

  // Integrator, debounce, inversion and divider conditions
  always_comb begin
    len_eff  = (len_q == '0) ? CNT_BITS'(1) : len_q;
    idx_inc  = idx_q + 1'b1;
    sum_add  = sum_q + SUM_BITS'(in_word_i.analog_sample);
    blk_done = (idx_inc >= len_eff);
    push_chg = (TW'(ticks_q) > TW'(deb_q)) && (in_word_i.pin_level != last_q);
    inv_val  = SAMPLE_MAX - in_word_i.analog_sample;
    rem_sh   = {rem_q, quot_q[SUM_BITS-1]};
    rem_ge   = (rem_sh >= {1'b0, len_eff});
  end

  always_comb begin
    stat_o.need_div = (in_word_i.cmd == CMD_QUERY) && (mode_q == MODE_INTEG) && blk_done;
    stat_o.div_last = (dcnt_q == DCNT_LAST);
  end

  // Item processing and divider steps
  always_comb begin
    last_d  = last_q;
    ticks_d = ticks_q;
    press_d = press_q;
    sum_d   = sum_q;
    idx_d   = idx_q;
    avg_d   = avg_q;
    rem_d   = rem_q;
    quot_d  = quot_q;
    dcnt_d  = dcnt_q;
    res_d   = res_q;

    if (cmd_i.take) begin
      res_d = '0;
      unique case (in_word_i.cmd)
        CMD_TICK: begin
          if (ticks_q != TICK_MAX) ticks_d = ticks_q + 1'b1;
        end
        CMD_LOAD: press_d = in_word_i.load_value;
        CMD_PARITY: press_d = {{(CNT_BITS-2){1'b0}}, press_q[0], in_word_i.load_value[0]};
        CMD_QUERY: begin
          case (mode_q)
            MODE_DIGITAL: res_d.state_bit = in_word_i.pin_level;
            MODE_SWITCH:  res_d.state_bit = ~in_word_i.pin_level;
            MODE_PUSH: begin
              if (push_chg) begin
                last_d  = in_word_i.pin_level;
                ticks_d = '0;
                if (!in_word_i.pin_level) press_d = press_q + 1'b1;
              end
              res_d.state_bit = press_d[0];
            end
            MODE_ANALOG: begin
              res_d.level_value = in_word_i.analog_sample;
              res_d.state_bit   = (in_word_i.analog_sample >= thresh_q);
            end
            MODE_INV_AN: begin
              res_d.level_value = inv_val;
              res_d.state_bit   = (inv_val >= thresh_q);
            end
            MODE_INTEG: begin
              res_d.level_value = avg_q;
              if (blk_done) begin
                sum_d  = '0;
                idx_d  = '0;
                quot_d = sum_add;
                rem_d  = '0;
                dcnt_d = '0;
              end else begin
                sum_d = sum_add;
                idx_d = idx_inc;
              end
            end
            default: ;
          endcase
        end
        default: ;
      endcase
      res_d.press_total = press_d;
    end

    // Restoring divide, one quotient bit per cycle
    if (cmd_i.div_step) begin
      rem_d  = rem_ge ? CNT_BITS'(rem_sh - {1'b0, len_eff}) : rem_sh[CNT_BITS-1:0];
      quot_d = {quot_q[SUM_BITS-2:0], rem_ge};
      dcnt_d = dcnt_q + 1'b1;
      if (stat_o.div_last) begin
        avg_d             = quot_d[SAMPLE_BITS-1:0];
        res_d.level_value = quot_d[SAMPLE_BITS-1:0];
      end
    end
  end

  // Config and qualifier state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= MODE_RESET;
      thresh_q <= THRESH_RESET;
      len_q    <= LEN_RESET;
      deb_q    <= DEBOUNCE_RESET;
      last_q   <= 1'b0;
      ticks_q  <= '0;
      press_q  <= '0;
      sum_q    <= '0;
      idx_q    <= '0;
      avg_q    <= '0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          REG_MODE:     mode_q   <= cfg_wdata_i[MODE_BITS-1:0];
          REG_THRESH:   thresh_q <= cfg_wdata_i[THR_BITS-1:0];
          REG_LEN:      len_q    <= cfg_wdata_i[CNT_BITS-1:0];
          REG_DEBOUNCE: deb_q    <= cfg_wdata_i[CNT_BITS-1:0];
          default: ;
        endcase
      end
      last_q  <= last_d;
      ticks_q <= ticks_d;
      press_q <= press_d;
      sum_q   <= sum_d;
      idx_q   <= idx_d;
      avg_q   <= avg_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    quot_q <= quot_d;
    dcnt_q <= dcnt_d;
    res_q  <= res_d;
    if (cmd_i.emit) out_q <= res_q;
  end

  assign out_word_o = out_q;

endmodule
`default_nettype wire

### rtl/multi_mode_input_qualifier.sv
// Top level of the multi-mode input qualifier.
// Usage:
//   Input channel (in_valid_i/in_ready_o, in_word_i) takes one word per item:
//   a tick, a query with pin level and sample, a press-count load or a
//   parity force. Every item returns exactly one output word on the
//   out_valid_o/out_ready_i channel, in order.
//   Configuration is a plain write port (cfg_we_i, cfg_idx_i, cfg_wdata_i):
//   0 mode, 1 threshold, 2 average length, 3 debounce ticks.
//   Most items go from accept straight to the emit state, where the word
//   enters the output register once that is free and out_valid_o rises. An
//   integrator query that closes a block first runs a restoring divider of
//   the 26-bit sum by the length, one quotient bit per cycle. A new item is
//   accepted only once the last item's word has entered the output register.
//   One item is in work at a time; the finished word sits in an output
//   register, so the next item is accepted and processed while the receiver
//   stalls; it then waits for the output register to free up.
//   Reset (rst_ni low, asynchronous) restores register defaults (mode 0,
//   threshold 700, length 1000, debounce 50) and clears all qualifier state.
`timescale 1ns / 1ps
`default_nettype none
module multi_mode_input_qualifier
  import mmiq_pkg::*;
#(
  parameter int TIME_BITS = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     in_valid_i,
  output logic                          in_ready_o,
  input  wire in_word_t                 in_word_i,
  output logic                          out_valid_o,
  input  wire logic                     out_ready_i,
  output out_word_t                     out_word_o,
  input  wire logic                     cfg_we_i,
  input  wire logic [CFG_IDX_BITS-1:0]  cfg_idx_i,
  input  wire logic [CFG_DATA_BITS-1:0] cfg_wdata_i
);

  ctl_cmd_t ctl_cmd;
  dp_stat_t dp_stat;

  mmiq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .stat_i      (dp_stat),
    .cmd_o       (ctl_cmd)
  );

  mmiq_dpath #(
    .TIME_BITS (TIME_BITS)
  ) u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_word_i   (in_word_i),
    .cmd_i       (ctl_cmd),
    .stat_o      (dp_stat),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .out_word_o  (out_word_o)
  );

endmodule
`default_nettype wire

### rtl/mmiq_checker.sv
// Port-level assertions for the multi-mode input qualifier, with bind.
`timescale 1ns / 1ps
`default_nettype none
module mmiq_checker
  import mmiq_pkg::*;
(
  input wire logic      clk_i,
  input wire logic      rst_ni,
  input wire logic      in_valid_i,
  input wire logic      in_ready_o,
  input wire in_word_t  in_word_i,
  input wire logic      out_valid_o,
  input wire logic      out_ready_i,
  input wire out_word_t out_word_o
);

  logic in_acc;
  assign in_acc = in_valid_i && in_ready_o;

  // Stalled output word holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_word_o))
    else $error("output word changed under stall");

  // One item in work at a time
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> !in_ready_o)
    else $error("input accepted while busy");

  // Tick word with free output gives a zero-state word via the emit state and output register
  a_tick_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && !out_valid_o && (in_word_i.cmd == CMD_TICK) |=>
      ##1 out_valid_o && !out_word_o.state_bit && (out_word_o.level_value == '0))
    else $error("tick result wrong or late");

  // Load word reports the loaded count
  a_load_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && !out_valid_o && (in_word_i.cmd == CMD_LOAD) |=>
      ##1 out_valid_o && (out_word_o.press_total == $past(in_word_i.load_value, 2)))
    else $error("load result wrong");

endmodule

bind multi_mode_input_qualifier mmiq_checker u_mmiq_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .in_word_i   (in_word_i),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_word_o  (out_word_o)
);
`default_nettype wire

### tb/sv/tb.sv
// Self-checking testbench for the multi-mode input qualifier.
`timescale 1ns / 1ps
module tb;
  import mmiq_pkg::*;

  localparam int TICK_BITS = 16;
  localparam logic [TICK_BITS-1:0] TICK_MAX = '1;
  localparam logic [MODE_BITS-1:0] MODE_SPARE6 = 3'd6;
  localparam logic [MODE_BITS-1:0] MODE_SPARE7 = 3'd7;
  localparam logic [CNT_BITS-1:0]  LEN_MAX = '1;
  localparam int CYCLE_LIMIT = 100_000;
  localparam int IDLE_PCT = 13;

  // DUT connections; the driven inputs are known from time zero
  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  in_word_t in_word_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  out_word_t out_word_o;
  logic cfg_we_i = 1'b0;
  logic [CFG_IDX_BITS-1:0] cfg_idx_i = '0;
  logic [CFG_DATA_BITS-1:0] cfg_wdata_i = '0;

  // Shadow registers and qualifier state of the predictor
  logic [MODE_BITS-1:0] cfg_mode = MODE_RESET;
  logic [THR_BITS-1:0]  cfg_thresh = THRESH_RESET;
  logic [CNT_BITS-1:0]  cfg_len = LEN_RESET;
  logic [CNT_BITS-1:0]  cfg_debounce = DEBOUNCE_RESET;
  logic                   pb_level = 1'b0;
  logic [TICK_BITS-1:0]   tick_count = '0;
  logic [CNT_BITS-1:0]    press_cnt = '0;
  logic [SUM_BITS-1:0]    acc_sum = '0;
  logic [CNT_BITS-1:0]    acc_index = '0;
  logic [SAMPLE_BITS-1:0] avg_value = '0;

  out_word_t awaited_out[$];
  out_word_t want;
  int errors = 0;
  int words_sent = 0;
  int words_checked = 0;
  int cycle_count = 0;
  bit quiet_run = 1'b0;

  multi_mode_input_qualifier #(.TIME_BITS(TICK_BITS)) u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_word_i   (in_word_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_word_o  (out_word_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Run limit
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Expected output word for one accepted input word; advances the shadow state
  function automatic out_word_t qualify_word(in_word_t w);
    out_word_t r;
    logic [CNT_BITS-1:0] len;
    logic [SUM_BITS-1:0] quot;
    r = '0;
    case (w.cmd)
      CMD_TICK: begin
        if (tick_count != TICK_MAX) tick_count = tick_count + 1'b1;
      end
      CMD_LOAD: press_cnt = w.load_value;
      CMD_PARITY: press_cnt = {{(CNT_BITS-2){1'b0}}, press_cnt[0], w.load_value[0]};
      default: begin
        case (cfg_mode)
          MODE_DIGITAL: r.state_bit = w.pin_level;
          MODE_PUSH: begin
            // level change taken only once the debounce time is exceeded
            if (tick_count > cfg_debounce && w.pin_level != pb_level) begin
              pb_level = w.pin_level;
              tick_count = '0;
              if (!w.pin_level) press_cnt = press_cnt + 1'b1;
            end
            r.state_bit = press_cnt[0];
          end
          MODE_SWITCH: r.state_bit = ~w.pin_level;
          MODE_ANALOG: begin
            r.level_value = w.analog_sample;
            r.state_bit = (w.analog_sample >= cfg_thresh);
          end
          MODE_INV_AN: begin
            r.level_value = SAMPLE_MAX - w.analog_sample;
            r.state_bit = (r.level_value >= cfg_thresh);
          end
          MODE_INTEG: begin
            // zero length behaves as one
            len = (cfg_len == '0) ? CNT_BITS'(1) : cfg_len;
            acc_sum = acc_sum + SUM_BITS'(w.analog_sample);
            acc_index = acc_index + 1'b1;
            if (acc_index >= len) begin
              quot = acc_sum / SUM_BITS'(len);
              avg_value = quot[SAMPLE_BITS-1:0];
              acc_sum = '0;
              acc_index = '0;
            end
            r.level_value = avg_value;
          end
          default: ;
        endcase
      end
    endcase
    r.press_total = press_cnt;
    return r;
  endfunction

  // Send one word, idling at random first; expectation recorded on accept
  task automatic issue_word(input logic [CMD_BITS-1:0] cmd, input logic pin,
                            input logic [SAMPLE_BITS-1:0] smp,
                            input logic [CNT_BITS-1:0] load);
    in_word_t w;
    w.cmd = cmd;
    w.pin_level = pin;
    w.analog_sample = smp;
    w.load_value = load;
    while (!quiet_run && $urandom_range(0, 99) < IDLE_PCT) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_word_i <= w;
    do @(posedge clk_i); while (!in_ready_o);
    awaited_out.push_back(qualify_word(w));
    words_sent++;
  endtask

  // Stop sending and wait until every output word is back
  task automatic settle();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (awaited_out.size() != 0);
    repeat (4) @(posedge clk_i);
  endtask

  // Register write, only with the block idle
  task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx,
                           input logic [CFG_DATA_BITS-1:0] data);
    settle();
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      REG_MODE:     cfg_mode = data[MODE_BITS-1:0];
      REG_THRESH:   cfg_thresh = data[THR_BITS-1:0];
      REG_LEN:      cfg_len = data;
      REG_DEBOUNCE: cfg_debounce = data;
      default: ;
    endcase
  endtask

  task automatic tick_run(input int n);
    int k;
    for (k = 0; k < n; k++)
      issue_word(CMD_TICK, 1'($urandom), SAMPLE_BITS'($urandom), CNT_BITS'($urandom));
  endtask

  // Query that asks for the opposite of the current push level
  task automatic toggle_query();
    issue_word(CMD_QUERY, ~pb_level, SAMPLE_BITS'($urandom), CNT_BITS'($urandom));
  endtask

  // Output checker and receiver stalls
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (awaited_out.size() == 0) begin
        $error("output word %h with nothing expected", out_word_o);
        errors++;
      end else begin
        want = awaited_out.pop_front();
        words_checked++;
        if (out_word_o.state_bit !== want.state_bit) begin
          $error("state_bit: expected %0d, actual %0d", want.state_bit, out_word_o.state_bit);
          errors++;
        end
        if (out_word_o.level_value !== want.level_value) begin
          $error("level_value: expected %0d, actual %0d",
                 want.level_value, out_word_o.level_value);
          errors++;
        end
        if (out_word_o.press_total !== want.press_total) begin
          $error("press_total: expected %0d, actual %0d",
                 want.press_total, out_word_o.press_total);
          errors++;
        end
      end
    end
    out_ready_i <= quiet_run || ($urandom_range(0, 99) >= IDLE_PCT);
  end

  // Reset values of all registers, before any write
  task automatic test_defaults();
    int k;
    issue_word(CMD_QUERY, 1'b0, SAMPLE_MAX, '1);
    issue_word(CMD_QUERY, 1'b1, '0, '0);
    // debounce 50: fifty ticks are not enough, the next one is
    write_reg(REG_MODE, CFG_DATA_BITS'(MODE_PUSH));
    tick_run(50);
    issue_word(CMD_QUERY, 1'b1, SAMPLE_BITS'($urandom), CNT_BITS'($urandom));
    tick_run(1);
    issue_word(CMD_QUERY, 1'b1, SAMPLE_BITS'($urandom), CNT_BITS'($urandom));
    // threshold 700
    write_reg(REG_MODE, CFG_DATA_BITS'(MODE_ANALOG));
    issue_word(CMD_QUERY, 1'b0, 10'd699, '0);
    issue_word(CMD_QUERY, 1'b1, 10'd700, '0);
    // length 1000: twenty samples close nothing, a shorter length then closes the block
    write_reg(REG_MODE, CFG_DATA_BITS'(MODE_INTEG));
    for (k = 0; k < 20; k++)
      issue_word(CMD_QUERY, 1'($urandom), SAMPLE_BITS'($urandom), CNT_BITS'($urandom));
    write_reg(REG_LEN, 16'd7);
    issue_word(CMD_QUERY, 1'b0, SAMPLE_MAX, '0);
  endtask

  // Each mode and command at the field extremes
  task automatic test_modes_directed();
    write_reg(REG_MODE, CFG_DATA_BITS'(MODE_DIGITAL));
    issue_word(CMD_QUERY, 1'b0, SAMPLE_MAX, '1);
    issue_word(CMD_QUERY, 1'b1, '0, '0);
    write_reg(REG_MODE, CFG_DATA_BITS'(MODE_SWITCH));
    issue_word(CMD_QUERY, 1'b0, '0, '0);
    issue_word(CMD_QUERY, 1'b1, SAMPLE_MAX, '1);
    write_reg(REG_MODE, CFG_DATA_BITS'(MODE_ANALOG));
    write_reg(REG_THRESH, '0);
    issue_word(CMD_QUERY, 1'b0, '0, '0);
    write_reg(REG_THRESH, 16'h03FF);
    issue_word(CMD_QUERY, 1'b1, 10'd1022, '1);
    issue_word(CMD_QUERY, 1'b0, SAMPLE_MAX, '0);
    // upper write bits beyond the register are dropped: threshold 512
    write_reg(REG_THRESH, 16'hFE00);
    write_reg(REG_MODE, CFG_DATA_BITS'(MODE_INV_AN));
    issue_word(CMD_QUERY, 1'b0, '0, '0);
    issue_word(CMD_QUERY, 1'b1, SAMPLE_MAX, '0);
    issue_word(CMD_QUERY, 1'b0, 10'd511, '0);
    issue_word(CMD_QUERY, 1'b0, 10'd512, '0);
    // spare mode codes answer zero state and level
    write_reg(REG_MODE, CFG_DATA_BITS'(MODE_SPARE6));
    issue_word(CMD_QUERY, 1'b1, SAMPLE_MAX, '1);
    write_reg(REG_MODE, 16'hFFFF);
    issue_word(CMD_QUERY, 1'b1, SAMPLE_MAX, '1);
    issue_word(CMD_TICK, 1'b1, SAMPLE_MAX, '1);
    issue_word(CMD_LOAD, 1'b0, '0, '1);
    issue_word(CMD_PARITY, 1'b1, SAMPLE_MAX, '0);
    issue_word(CMD_PARITY, 1'b0, '0, 16'h0001);
    issue_word(CMD_LOAD, 1'b1, SAMPLE_MAX, '0);
    issue_word(CMD_PARITY, 1'b0, '0, 16'hFFFE);
  endtask

  // Debounce boundaries, release counting and count wrap
  task automatic test_push_debounce();
    write_reg(REG_MODE, CFG_DATA_BITS'(MODE_PUSH));
    write_reg(REG_DEBOUNCE, '0);
    issue_word(CMD_LOAD, 1'b0, '0, '0);
    tick_run(1);
    toggle_query();
    toggle_query();
    tick_run(1);
    toggle_query();
    tick_run(1);
    issue_word(CMD_QUERY, pb_level, '0, '0);
    write_reg(REG_DEBOUNCE, 16'd3);
    tick_run(3);
    toggle_query();
    tick_run(1);
    toggle_query();
    // release from 0xFFFF wraps to zero
    issue_word(CMD_LOAD, 1'b0, '0, '1);
    tick_run(4);
    issue_word(CMD_QUERY, 1'b1, '0, '0);
    tick_run(4);
    issue_word(CMD_QUERY, 1'b0, '0, '0);
    issue_word(CMD_PARITY, 1'b0, '0, 16'h0001);
    issue_word(CMD_QUERY, pb_level, SAMPLE_MAX, '1);
  endtask

  // Zero, small, lowered and largest block lengths
  task automatic test_integrator();
    int k;
    write_reg(REG_MODE, CFG_DATA_BITS'(MODE_INTEG));
    write_reg(REG_LEN, '0);
    issue_word(CMD_QUERY, 1'b0, SAMPLE_MAX, '0);
    issue_word(CMD_QUERY, 1'b1, 10'd5, '0);
    write_reg(REG_LEN, 16'd1);
    issue_word(CMD_QUERY, 1'b0, '0, '0);
    write_reg(REG_LEN, 16'd3);
    issue_word(CMD_QUERY, 1'b0, 10'd1, '0);
    issue_word(CMD_TICK, 1'b0, 10'd9, '0);
    issue_word(CMD_QUERY, 1'b0, 10'd2, '0);
    issue_word(CMD_QUERY, 1'b0, 10'd4, '0);
    // length lowered under the running index closes on the next sample
    write_reg(REG_LEN, 16'd10);
    for (k = 0; k < 5; k++)
      issue_word(CMD_QUERY, 1'($urandom), SAMPLE_BITS'($urandom_range(600, 1023)), '0);
    write_reg(REG_LEN, 16'd2);
    issue_word(CMD_QUERY, 1'b0, SAMPLE_MAX, '0);
    // top-scale samples under the largest length, closed by length one:
    // the quotient overflows the level field and is truncated
    write_reg(REG_LEN, LEN_MAX);
    for (k = 0; k < 9; k++)
      issue_word(CMD_QUERY, 1'($urandom), SAMPLE_MAX, CNT_BITS'($urandom));
    write_reg(REG_LEN, 16'd1);
    issue_word(CMD_QUERY, 1'b0, SAMPLE_MAX, '0);
  endtask

  // Largest debounce values hold off level changes over a long tick run, a lower one lets one through
  task automatic test_debounce_limit();
    quiet_run = 1'b1;
    write_reg(REG_MODE, CFG_DATA_BITS'(MODE_PUSH));
    write_reg(REG_DEBOUNCE, '1);
    tick_run(120);
    toggle_query();
    write_reg(REG_DEBOUNCE, 16'hFFFE);
    toggle_query();
    write_reg(REG_DEBOUNCE, 16'd100);
    toggle_query();
    tick_run(1);
    settle();
    quiet_run = 1'b0;
  endtask

  // Random phases, one mode each, with random register settings
  task automatic test_random();
    int phase;
    int k;
    int pick;
    logic [CFG_DATA_BITS-1:0] data;
    logic [MODE_BITS-1:0] pmode;
    logic pin;
    logic [CMD_BITS-1:0] cmd;
    logic [CNT_BITS-1:0] load;
    for (phase = 0; phase < 12; phase++) begin
      quiet_run = (phase == 4);
      pmode = (phase == 11) ? (MODE_SPARE6 | MODE_BITS'($urandom_range(0, 1)))
                            : MODE_BITS'(phase % 6);
      data = CFG_DATA_BITS'($urandom);
      data[MODE_BITS-1:0] = pmode;
      write_reg(REG_MODE, data);
      pick = $urandom_range(0, 9);
      data = CFG_DATA_BITS'($urandom);
      if (pick == 0) data[THR_BITS-1:0] = '0;
      if (pick == 1) data[THR_BITS-1:0] = '1;
      write_reg(REG_THRESH, data);
      case ($urandom_range(0, 9))
        0: data = '0;
        1: data = 16'd1;
        9: data = CFG_DATA_BITS'($urandom_range(9, 60));
        default: data = CFG_DATA_BITS'($urandom_range(2, 8));
      endcase
      write_reg(REG_LEN, data);
      case ($urandom_range(0, 9))
        0: data = '1;
        1: data = CFG_DATA_BITS'($urandom);
        default: data = CFG_DATA_BITS'($urandom_range(0, 3));
      endcase
      write_reg(REG_DEBOUNCE, data);
      for (k = 0; k < 45; k++) begin
        pick = $urandom_range(0, 99);
        if (pick < 40) cmd = CMD_TICK;
        else if (pick < 85) cmd = CMD_QUERY;
        else if (pick < 93) cmd = CMD_LOAD;
        else cmd = CMD_PARITY;
        // push phases mostly ask for a real level change
        pin = (pmode == MODE_PUSH && $urandom_range(0, 9) < 7) ? ~pb_level : 1'($urandom);
        case ($urandom_range(0, 9))
          0: load = '0;
          1: load = '1;
          default: load = CNT_BITS'($urandom);
        endcase
        issue_word(cmd, pin, SAMPLE_BITS'($urandom), load);
        if ($urandom_range(0, 199) == 0) settle();
      end
    end
    quiet_run = 1'b0;
  endtask

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_defaults();
    test_modes_directed();
    test_push_debounce();
    test_integrator();
    test_debounce_limit();
    test_random();
    settle();
    repeat (40) @(posedge clk_i);
    $display("Sent %0d words and checked %0d results over six modes and spare codes,",
             words_sent, words_checked);
    $display("debounce limits, count wrap, zero and lowered lengths and average truncation.");
    if (errors == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule

### files.f
rtl/mmiq_pkg.sv
rtl/mmiq_ctrl.sv
rtl/mmiq_dpath.sv
rtl/multi_mode_input_qualifier.sv
rtl/mmiq_checker.sv
tb/sv/tb.sv
